[hw/rtl/mwgp_pkg.sv]
`timescale 1ns / 1ps
package mwgp_pkg;

    localparam int WIN        = 7;
    localparam int WIN_N      = WIN * WIN;
    localparam int STORE_ROWS = WIN - 1;
    localparam int CTR_IDX    = (WIN / 2) * WIN + (WIN / 2);
    localparam int INNER_N    = 24;
    localparam int RING_N     = 28;
    localparam int SEQ_N      = INNER_N + RING_N;
    localparam int PIX_W      = 17;

    // configuration register indexes
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;

    typedef logic [PIX_W-1:0] t_pix;
    typedef logic [WIN_N-1:0][PIX_W-1:0] t_win;

    typedef struct packed {
        t_win win;
        logic last;
    } t_item;

    // window positions (row * WIN + column) in accumulation order:
    // inner square by column then row without its last element, then the ring
    // top row, bottom row, left column, right column
    localparam logic [5:0] SEQ_IDX [SEQ_N] = '{
        6'd8,  6'd15, 6'd22, 6'd29, 6'd36,
        6'd9,  6'd16, 6'd23, 6'd30, 6'd37,
        6'd10, 6'd17, 6'd24, 6'd31, 6'd38,
        6'd11, 6'd18, 6'd25, 6'd32, 6'd39,
        6'd12, 6'd19, 6'd26, 6'd33,
        6'd0,  6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd6,
        6'd42, 6'd43, 6'd44, 6'd45, 6'd46, 6'd47, 6'd48,
        6'd0,  6'd7,  6'd14, 6'd21, 6'd28, 6'd35, 6'd42,
        6'd6,  6'd13, 6'd20, 6'd27, 6'd34, 6'd41, 6'd48
    };

endpackage

[hw/rtl/mwgp_ram.sv]
`timescale 1ns / 1ps
module mwgp_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[hw/rtl/mwgp_front.sv]
`timescale 1ns / 1ps
module mwgp_front #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [15:0]    i_prob,
    input  logic           i_mask,
    input  logic [10:0]    i_width,
    input  logic [15:0]    i_height,
    input  logic           i_full,
    output logic           o_push,
    output mwgp_pkg::t_item o_item
);
    import mwgp_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = ($clog2(MAX_WIDTH + 1) > 11) ? $clog2(MAX_WIDTH + 1) : 11;

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_RD   = 2'd1;
    localparam logic [1:0] F_SH   = 2'd2;

    logic [1:0]    r_state;
    logic [CW-1:0] r_col;
    logic [15:0]   r_row;
    logic [CW-1:0] r_x;
    logic [15:0]   r_y;
    logic          r_last;
    t_pix          r_px;
    logic [2:0]    r_ysl;
    t_win          r_win;
    t_win          n_win;

    logic [WW-1:0] w_cfg, w_eff, xw;
    logic [15:0]   h_eff, yv;
    logic          accept;
    logic [31:0]   div_prod;
    logic [16:0]   q6;
    logic [15:0]   rem6;
    logic [3:0]    sl;
    t_pix          rd [STORE_ROWS];

    assign o_ready = (r_state == F_IDLE) && !i_full;
    assign accept  = i_valid && o_ready;

    // size clamping and counter clamping
    always_comb begin
        w_cfg = WW'(i_width);
        if (w_cfg < WW'(WIN)) begin
            w_eff = WW'(WIN);
        end else if (w_cfg > WW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = w_cfg;
        end
        h_eff = (i_height < 16'(WIN)) ? 16'(WIN) : i_height;
        xw    = (WW'(r_col) >= w_eff) ? w_eff - WW'(1) : WW'(r_col);
        yv    = (r_row >= h_eff) ? h_eff - 16'd1 : r_row;
    end

    // row slot: y mod 6 by reciprocal multiply
    always_comb begin
        div_prod = r_y * 32'd43691;
        q6       = 17'(div_prod[31:18]) * 17'd6;
        rem6     = r_y - q6[15:0];
    end

    genvar gs;
    generate
        for (gs = 0; gs < STORE_ROWS; gs++) begin : g_rows
            mwgp_ram #(
                .WIDTH (PIX_W),
                .DEPTH (MAX_WIDTH)
            ) u_row (
                .i_clk   (i_clk),
                .i_we    ((r_state == F_SH) && (r_ysl == 3'(gs))),
                .i_waddr (r_x),
                .i_wdata (r_px),
                .i_raddr (r_x),
                .o_rdata (rd[gs])
            );
        end
    endgenerate

    // window shift with the new column from the row store
    always_comb begin
        n_win = r_win;
        sl    = '0;
        for (int r = 0; r < WIN; r++) begin
            for (int c = 0; c < WIN - 1; c++) begin
                n_win[r * WIN + c] = r_win[r * WIN + c + 1];
            end
        end
        for (int k = 1; k <= STORE_ROWS; k++) begin
            sl = {1'b0, r_ysl} + 4'(STORE_ROWS - k);
            if (sl >= 4'(STORE_ROWS)) begin
                sl = sl - 4'(STORE_ROWS);
            end
            n_win[(WIN - 1 - k) * WIN + WIN - 1] = rd[sl[2:0]];
        end
        n_win[WIN_N - 1] = r_px;
    end

    assign o_push      = (r_state == F_SH) && (r_x >= CW'(WIN - 1)) && (r_y >= 16'(WIN - 1));
    assign o_item.win  = n_win;
    assign o_item.last = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_col   <= '0;
            r_row   <= '0;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (accept) begin
                        r_px   <= {i_mask, i_prob};
                        r_x    <= xw[CW-1:0];
                        r_y    <= yv;
                        r_last <= (xw == w_eff - WW'(1)) && (yv == h_eff - 16'd1);
                        if (xw == w_eff - WW'(1)) begin
                            r_col <= '0;
                            r_row <= (yv == h_eff - 16'd1) ? 16'd0 : yv + 16'd1;
                        end else begin
                            r_col <= xw[CW-1:0] + CW'(1);
                            r_row <= yv;
                        end
                        r_state <= F_RD;
                    end
                end
                F_RD: begin
                    r_ysl   <= rem6[2:0];
                    r_state <= F_SH;
                end
                F_SH: begin
                    r_win   <= n_win;
                    r_state <= F_IDLE;
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end
endmodule

[hw/rtl/mwgp_queue.sv]
`timescale 1ns / 1ps
module mwgp_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mwgp_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_head_valid,
    output mwgp_pkg::t_item o_head
);
    import mwgp_pkg::*;

    localparam int QDEPTH = 2;

    t_item      r_mem [QDEPTH];
    logic       r_wp, r_rp;
    logic [1:0] r_count;
    logic       do_pop;

    assign o_full       = (r_count == 2'(QDEPTH));
    assign o_head_valid = (r_count != 2'd0);
    assign o_head       = r_mem[r_rp];
    assign do_pop       = i_pop && o_head_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (do_pop) r_rp <= ~r_rp;
            r_count <= r_count + 2'(i_push) - 2'(do_pop);
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !do_pop)) else $error("queue push while full");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'(QDEPTH)) else $error("queue count out of range");
    a_pointers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd0 || r_count == 2'(QDEPTH)) |-> (r_wp == r_rp))
        else $error("queue pointers disagree with count");
`endif
endmodule

[hw/rtl/mwgp_back.sv]
`timescale 1ns / 1ps
module mwgp_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_head_valid,
    input  mwgp_pkg::t_item i_head,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [20:0]     o_inner,
    output logic [20:0]     o_ring,
    output logic [15:0]     o_glitch,
    output logic            o_last
);
    import mwgp_pkg::*;

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_ACC  = 3'd1;
    localparam logic [2:0] B_PREP = 3'd2;
    localparam logic [2:0] B_MUL  = 3'd3;
    localparam logic [2:0] B_SUM  = 3'd4;
    localparam logic [2:0] B_DIV  = 3'd5;
    localparam logic [2:0] B_OUT  = 3'd6;

    typedef struct packed {
        logic [20:0] sum;
        logic [32:0] pf;
        logic [32:0] pb;
        logic        ok;
    } t_acc;

    localparam t_acc ACC_START = '{sum: 21'd0, pf: 33'h1_0000_0000,
                                   pb: 33'h1_0000_0000, ok: 1'b1};

    logic [2:0]  r_phase;
    logic [5:0]  r_k;
    logic [2:0]  r_m;
    logic [4:0]  r_i;
    t_acc        r_acc, r_in;
    logic [32:0] r_g [4];
    logic [49:0] r_t;
    logic [48:0] r_rem;
    logic [50:0] r_dsh;
    logic [16:0] r_q;
    logic [20:0] r_inner, r_ring;
    logic        r_out_valid;
    logic [20:0] r_o_inner, r_o_ring;
    logic [15:0] r_o_glitch;
    logic        r_o_last;

    t_acc        acc_in, acc_nx;
    t_pix        pix;
    logic [16:0] pvb;
    logic [48:0] prod_f;
    logic [49:0] prod_b;
    logic        center, in_ok, ring_ok;
    logic [20:0] inner_v;
    logic [32:0] mul_a, mul_bsel;
    logic [16:0] mul_b;
    logic [49:0] mul_p;
    logic [50:0] gsum;
    logic [34:0] dsum;
    logic        fits;
    logic        out_free;

    // one factor of the current set per step
    always_comb begin
        acc_in = ((r_k == 6'd0) || (r_k == 6'(INNER_N))) ? ACC_START : r_acc;
        pix    = i_head.win[SEQ_IDX[r_k]];
        pvb    = 17'h1_0000 - {1'b0, pix[15:0]};
        prod_f = 49'(acc_in.pf) * 49'(pix[15:0]);
        prod_b = 50'(acc_in.pb) * 50'(pvb);
        acc_nx = acc_in;
        if (acc_in.ok) begin
            if (!pix[16]) begin
                acc_nx.ok = 1'b0;
            end else begin
                acc_nx.sum = acc_in.sum + 21'(pix[15:0]);
                acc_nx.pf  = prod_f[48:16];
                acc_nx.pb  = prod_b[48:16];
            end
        end
    end

    always_comb begin
        center  = i_head.win[CTR_IDX][16];
        in_ok   = center && r_in.ok;
        ring_ok = center && r_acc.ok;
        inner_v = in_ok ? r_in.sum : 21'd0;
    end

    // Q1.32 product in two partial products, one per cycle
    always_comb begin
        mul_a    = r_g[r_m[2:1]];
        mul_bsel = (r_m[2:1] < 2'd2) ? r_acc.pb : r_acc.pf;
        mul_b    = r_m[0] ? {1'b0, mul_bsel[15:0]} : mul_bsel[32:16];
        mul_p    = 50'(mul_a) * 50'(mul_b);
        gsum     = 51'(r_t) + 51'(mul_p[49:16]);
        dsum     = 35'(r_g[0]) + 35'(r_g[1]) + 35'(r_g[2]) + 35'(r_g[3]);
        fits     = ({2'b00, r_rem} >= r_dsh);
    end

    assign out_free = !r_out_valid || i_ready;
    assign o_pop    = (r_phase == B_OUT) && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_phase)
                B_IDLE: begin
                    r_k <= 6'd0;
                    if (i_head_valid) r_phase <= B_ACC;
                end
                B_ACC: begin
                    r_acc <= acc_nx;
                    if (r_k == 6'(INNER_N - 1)) r_in <= acc_nx;
                    if (r_k == 6'(SEQ_N - 1)) begin
                        r_k     <= 6'd0;
                        r_phase <= B_PREP;
                    end else begin
                        r_k <= r_k + 6'd1;
                    end
                end
                B_PREP: begin
                    r_inner <= inner_v;
                    r_g[0]  <= in_ok ? r_in.pf : 33'd0;
                    r_g[1]  <= in_ok ? r_in.pb : 33'd0;
                    r_g[2]  <= in_ok ? r_in.pf : 33'd0;
                    r_g[3]  <= in_ok ? r_in.pb : 33'd0;
                    if (!ring_ok) begin
                        r_ring <= 21'd0;
                    end else if (r_acc.sum >= inner_v) begin
                        r_ring <= r_acc.sum - inner_v;
                    end else begin
                        r_ring <= inner_v - r_acc.sum;
                    end
                    r_m     <= 3'd0;
                    r_phase <= ring_ok ? B_MUL : B_SUM;
                end
                B_MUL: begin
                    if (!r_m[0]) begin
                        r_t <= mul_p;
                    end else begin
                        r_g[r_m[2:1]] <= gsum[48:16];
                    end
                    r_m <= r_m + 3'd1;
                    if (r_m == 3'd7) r_phase <= B_SUM;
                end
                B_SUM: begin
                    if (r_g[1] == 33'd0) begin
                        r_q     <= r_g[0][32:16];
                        r_phase <= B_OUT;
                    end else begin
                        r_rem   <= {r_g[0], 16'd0};
                        r_dsh   <= {dsum, 16'd0};
                        r_q     <= 17'd0;
                        r_i     <= 5'd16;
                        r_phase <= B_DIV;
                    end
                end
                B_DIV: begin
                    if (fits) r_rem <= r_rem - r_dsh[48:0];
                    r_q   <= {r_q[15:0], fits};
                    r_dsh <= r_dsh >> 1;
                    r_i   <= r_i - 5'd1;
                    if (r_i == 5'd0) r_phase <= B_OUT;
                end
                B_OUT: begin
                    if (out_free) begin
                        r_o_inner   <= r_inner;
                        r_o_ring    <= r_ring;
                        r_o_glitch  <= r_q[16] ? 16'hFFFF : r_q[15:0];
                        r_o_last    <= i_head.last;
                        r_phase     <= B_IDLE;
                    end
                end
                default: r_phase <= B_IDLE;
            endcase
        end
    end

    assign o_valid  = r_out_valid;
    assign o_inner  = r_o_inner;
    assign o_ring   = r_o_ring;
    assign o_glitch = r_o_glitch;
    assign o_last   = r_o_last;

`ifndef ASSERT_OFF
    a_head_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != B_IDLE) |-> i_head_valid) else $error("working without a queued window");
    a_pop_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_out_valid) else $error("pop without a result");
    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == B_DIV) |-> (r_i <= 5'd16)) else $error("divider step out of range");
`endif
endmodule

[hw/rtl/masked_window_glitch_probability.sv]
`timescale 1ns / 1ps
// channel | direction | handshake                        | payload
// s_axis  | in        | i_s_axis_tvalid / o_s_axis_tready | tdata probability, tuser mask
// m_axis  | out       | o_m_axis_tvalid / i_m_axis_tready | tdata sums and glitch, tlast
// cfg     | in        | i_cfg_valid / o_cfg_ready         | i_cfg_index, i_cfg_data
//
// a pixel request passes the front end as a store read and then a window shift
// the back end takes 52 accumulate steps with a 33x16 and a 33x17 multiplier,
// then forms four products with the ring factors on one shared 33x17 multiplier
// when ring and centre are valid, and runs 17 divider steps if the back-back product is non-zero
// a two-entry window queue lets the front keep taking pixels while the back works
// synchronous active-low reset clears counters, state and queue; the row store
// is not cleared and holds whatever it held until rows are written
// the result register frees the back end as soon as the sink takes the result
module masked_window_glitch_probability #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,  // [15:0] pixel_probability
    input  logic        i_s_axis_tuser,  // [0] pixel_valid_mask
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [20:0] inner_area_sum, [41:21] ring_difference, [57:42] glitch_probability
    output logic [63:0] o_m_axis_tdata,
    output logic        o_m_axis_tlast,  // last_of_frame
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import mwgp_pkg::*;

    logic [10:0] r_width;
    logic [15:0] r_height;

    logic        push, full, pop, head_valid;
    t_item       item, head;
    logic [20:0] res_inner, res_ring;
    logic [15:0] res_glitch;
    logic        res_last;

    // configuration registers, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 11'd1024;
            r_height <= 16'd1024;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_WIDTH:  r_width  <= i_cfg_data[10:0];
                REG_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // front: counters, row store and window
    mwgp_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .o_ready  (o_s_axis_tready),
        .i_prob   (i_s_axis_tdata),
        .i_mask   (i_s_axis_tuser),
        .i_width  (r_width),
        .i_height (r_height),
        .i_full   (full),
        .o_push   (push),
        .o_item   (item)
    );

    // windows waiting for the arithmetic
    mwgp_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_item       (item),
        .o_full       (full),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    // back: set sums, products and the normalising divide
    mwgp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_inner      (res_inner),
        .o_ring       (res_ring),
        .o_glitch     (res_glitch),
        .o_last       (res_last)
    );

    assign o_m_axis_tdata = {6'd0, res_glitch, res_ring, res_inner};
    assign o_m_axis_tlast = res_last;
endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
module tb;
    import mwgp_pkg::*;

    localparam int MAXW       = 1024;
    localparam int IDLE_LIMIT = 4000;

    typedef enum int {
        PK_ALL_MAX, PK_ALL_ZERO, PK_BLOB, PK_SMALL, PK_MIXED, PK_NOISY_MASK, PK_HOLE
    } t_pix_kind;

    typedef struct {
        logic [20:0] inner;
        logic [20:0] ring;
        logic [15:0] glitch;
        logic        last;
    } t_glitch_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [15:0] i_s_axis_tdata = '0;
    logic        i_s_axis_tuser = 1'b0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [63:0] o_m_axis_tdata;
    logic        o_m_axis_tlast;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = REG_WIDTH;
    logic [15:0] i_cfg_data = '0;

    masked_window_glitch_probability #(.MAX_WIDTH(MAXW)) dut (.*);

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // predictor state
    logic [16:0] line_mem [STORE_ROWS][MAXW];
    logic [16:0] pix_win [WIN][WIN];
    int unsigned col_pos, row_pos, img_w, img_h;

    t_glitch_res expected_q [$];
    int  errors = 0;
    int  pixels_sent = 0;
    int  results_seen = 0;
    int  frames_sent = 0;
    bit  src_no_gaps = 0;
    bit  snk_no_gaps = 0;
    int  idle_cycles = 0;

    function automatic void take_pixel(input logic [16:0] px, inout bit ok,
                                       inout longint unsigned sum, pf, pb);
        longint unsigned v;
        v = px[15:0];
        if (!ok) return;
        if (!px[16]) begin
            ok = 0;
            return;
        end
        sum += v;
        pf = (pf * v) >> 16;
        pb = (pb * (65536 - v)) >> 16;
    endfunction

    function automatic longint unsigned q32_mul(longint unsigned a, longint unsigned b);
        return (a * (b >> 16) + ((a * (b & 64'hFFFF)) >> 16)) >> 16;
    endfunction

    // advances the window model by one pixel; returns 1 when a result is due
    function automatic bit predict_pixel(input logic [15:0] prob, input logic msk,
                                         output t_glitch_res res);
        int unsigned w, h, x, y, slot;
        logic [16:0] px;
        bit last, iok, ook;
        longint unsigned isum, ipf, ipb, osum, opf, opb;
        longint unsigned inner, ring, gb, gbb, gff, gfb, g;
        w = (img_w < 7) ? 7 : (img_w > MAXW) ? MAXW : img_w;
        h = (img_h < 7) ? 7 : img_h;
        x = (col_pos >= w) ? w - 1 : col_pos;
        y = (row_pos >= h) ? h - 1 : row_pos;
        px = {msk, prob};
        for (int r = 0; r < WIN; r++)
            for (int c = 0; c < WIN - 1; c++)
                pix_win[r][c] = pix_win[r][c+1];
        for (int k = 1; k <= STORE_ROWS; k++) begin
            slot = (y % STORE_ROWS + STORE_ROWS - k) % STORE_ROWS;
            pix_win[WIN-1-k][WIN-1] = line_mem[slot][x];
        end
        pix_win[WIN-1][WIN-1] = px;
        line_mem[y % STORE_ROWS][x] = px;
        last = (x == w - 1) && (y == h - 1);
        if (x + 1 >= w) begin
            col_pos = 0;
            row_pos = (y + 1 >= h) ? 0 : y + 1;
        end else begin
            col_pos = x + 1;
            row_pos = y;
        end
        res = '{default: '0};
        if (x < WIN - 1 || y < WIN - 1) return 0;
        inner = 0; ring = 0; gb = 0; gbb = 0; gff = 0; gfb = 0;
        if (pix_win[3][3][16]) begin
            iok = 1; isum = 0; ipf = 64'd1 << 32; ipb = 64'd1 << 32;
            for (int dx = -2; dx <= 2; dx++)
                for (int dy = -2; dy <= 2; dy++)
                    if (!(dx == 2 && dy == 2))
                        take_pixel(pix_win[3+dy][3+dx], iok, isum, ipf, ipb);
            if (iok) begin
                inner = isum; gb = ipf; gbb = ipb; gff = ipf; gfb = ipb;
            end
            ook = 1; osum = 0; opf = 64'd1 << 32; opb = 64'd1 << 32;
            // ring order: top row, bottom row, left column, right column
            for (int k = -3; k <= 3; k++) take_pixel(pix_win[0][3+k], ook, osum, opf, opb);
            for (int k = -3; k <= 3; k++) take_pixel(pix_win[6][3+k], ook, osum, opf, opb);
            for (int k = -3; k <= 3; k++) take_pixel(pix_win[3+k][0], ook, osum, opf, opb);
            for (int k = -3; k <= 3; k++) take_pixel(pix_win[3+k][6], ook, osum, opf, opb);
            if (ook) begin
                ring = (osum >= inner) ? osum - inner : inner - osum;
                gb  = q32_mul(gb, opb);
                gbb = q32_mul(gbb, opb);
                gff = q32_mul(gff, opf);
                gfb = q32_mul(gfb, opf);
            end
        end
        if (gbb == 0) g = gb >> 16;
        else g = (gb << 16) / (gbb + gff + gfb + gb);
        if (g > 65535) g = 65535;
        res.inner  = inner[20:0];
        res.ring   = ring[20:0];
        res.glitch = g[15:0];
        res.last   = last;
        return 1;
    endfunction

    function automatic void make_pixel(input t_pix_kind kind, input int x, input int y,
                                       output logic [15:0] prob, output logic msk);
        int sel;
        sel = $urandom_range(0, 99);
        msk = (sel < 97);
        case (kind)
            PK_ALL_MAX:  begin prob = 16'hFFFF; msk = 1'b1; end
            PK_ALL_ZERO: begin prob = 16'h0000; msk = 1'b1; end
            PK_SMALL:    prob = 16'($urandom_range(0, 1500));
            // bright 5x5 patches on a dark background, so the inner and ring
            // products both survive at the patch centres
            PK_BLOB: begin
                if ((x % 7) inside {[1:5]} && (y % 7) inside {[1:5]})
                    prob = 16'($urandom_range(64000, 65535));
                else
                    prob = 16'($urandom_range(0, 1500));
            end
            PK_NOISY_MASK: begin
                prob = 16'($urandom);
                msk = (sel < 75);
            end
            // masked only on a grid of pixels and valid everywhere else
            PK_HOLE: begin
                prob = 16'($urandom);
                msk = !((x % 4) == 1 && (y % 3) == 0);
            end
            default: begin
                case (sel % 5)
                    0: prob = 16'h0000;
                    1: prob = 16'hFFFF;
                    2: prob = 16'($urandom_range(0, 2000));
                    3: prob = 16'($urandom_range(63000, 65535));
                    default: prob = 16'($urandom);
                endcase
            end
        endcase
    endfunction

    // one pixel request, with a random hold-off before it
    task automatic send_pixel(input logic [15:0] prob, input logic msk);
        int gap;
        t_glitch_res res;
        gap = src_no_gaps ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= prob;
        i_s_axis_tuser  <= msk;
        do @(posedge i_clk); while (!o_s_axis_tready);
        pixels_sent++;
        if (predict_pixel(prob, msk, res)) expected_q = {expected_q, res};
    endtask

    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        // pixels that raise no result may still sit in the front end
        repeat (16) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == REG_WIDTH) img_w = {21'd0, val[10:0]};
        else if (idx == REG_HEIGHT) img_h = {16'd0, val};
    endtask

    task automatic send_frame(input int w, input int h, input t_pix_kind kind);
        logic [15:0] prob;
        logic        msk;
        for (int y = 0; y < h; y++)
            for (int x = 0; x < w; x++) begin
                make_pixel(kind, x, y, prob, msk);
                send_pixel(prob, msk);
            end
        frames_sent++;
    endtask

    // smallest frame, both sizes below range and clamped up; extreme values
    task automatic test_directed_extremes();
        write_reg(REG_WIDTH, 16'd0);
        write_reg(REG_HEIGHT, 16'd3);
        send_frame(7, 7, PK_ALL_MAX);
        send_frame(7, 7, PK_ALL_ZERO);
        write_reg(REG_WIDTH, 16'd7);
        write_reg(REG_HEIGHT, 16'd7);
        send_frame(7, 7, PK_MIXED);
    endtask

    task automatic test_unmasked_centre();
        write_reg(REG_WIDTH, 16'd10);
        write_reg(REG_HEIGHT, 16'd8);
        send_frame(10, 8, PK_HOLE);
        send_frame(10, 8, PK_NOISY_MASK);
    endtask

    // full height register, then the frame is cut short while idle:
    // the row counter lands beyond the new height and counts as the last row
    task automatic test_tall_then_shrink();
        write_reg(REG_WIDTH, 16'd7);
        write_reg(REG_HEIGHT, 16'hFFFF);
        send_frame(7, 8, PK_MIXED);
        write_reg(REG_HEIGHT, 16'd8);
        send_frame(7, 1, PK_MIXED);
    endtask

    task automatic test_random_frames();
        int w, h, budget;
        t_pix_kind kind;
        bit held;
        budget = 420;
        held = 1'b0;
        while (budget > 0) begin
            w = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 40) : $urandom_range(7, 16);
            h = $urandom_range(7, 10);
            kind = t_pix_kind'($urandom_range(0, 6));
            if ($urandom_range(0, 3) == 0) kind = PK_BLOB;
            src_no_gaps = ($urandom_range(0, 3) == 0);
            snk_no_gaps = ($urandom_range(0, 3) == 0);
            write_reg(REG_WIDTH, 16'(w));
            write_reg(REG_HEIGHT, 16'(h));
            send_frame(w / 2, 1, kind);
            // hold the source until the back end has caught up
            if (!held && budget < 210) begin
                i_s_axis_tvalid <= 1'b0;
                while (expected_q.size() != 0) @(posedge i_clk);
                held = 1'b1;
            end
            send_frame(w, h - 1, kind);
            for (int x = 0; x < w - w / 2; x++)
                send_pixel(16'($urandom), $urandom_range(0, 9) != 0);
            budget -= w * h;
        end
        src_no_gaps = 0;
        snk_no_gaps = 0;
    endtask

    // result sink with random back-pressure
    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            gap = snk_no_gaps ? 0 : $urandom_range(0, 19);
            if (gap > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_glitch_res exp_r;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            results_seen++;
            if (expected_q.size() == 0) begin
                $error("unexpected result, tdata %h", o_m_axis_tdata);
                errors++;
            end else begin
                exp_r = expected_q.pop_front();
                if (o_m_axis_tdata[20:0] !== exp_r.inner) begin
                    $error("inner_area_sum: expected %0d, got %0d",
                           exp_r.inner, o_m_axis_tdata[20:0]);
                    errors++;
                end
                if (o_m_axis_tdata[41:21] !== exp_r.ring) begin
                    $error("ring_difference: expected %0d, got %0d",
                           exp_r.ring, o_m_axis_tdata[41:21]);
                    errors++;
                end
                if (o_m_axis_tdata[57:42] !== exp_r.glitch) begin
                    $error("glitch_probability: expected %0d, got %0d",
                           exp_r.glitch, o_m_axis_tdata[57:42]);
                    errors++;
                end
                if (o_m_axis_tlast !== exp_r.last) begin
                    $error("last_of_frame: expected %0d, got %0d",
                           exp_r.last, o_m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no request moving on any channel
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
            || (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
            $display("** masked_window_glitch_probability: FAILED **");
            $finish;
        end
    end

    initial begin
        col_pos = 0;
        row_pos = 0;
        img_w = 1024;
        img_h = 1024;
        for (int r = 0; r < WIN; r++)
            for (int c = 0; c < WIN; c++)
                pix_win[r][c] = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_extremes();
        test_unmasked_centre();
        test_tall_then_shrink();
        test_random_frames();
        drain_results();
        repeat (200) @(posedge i_clk);
        $display("covered %0d frames, %0d pixels, %0d results checked",
                 frames_sent, pixels_sent, results_seen);
        $display("sizes from the clamped minimum up to 40 columns, masked and unmasked sets");
        if (errors == 0 && expected_q.size() == 0)
            $display("** masked_window_glitch_probability: PASSED **");
        else
            $display("** masked_window_glitch_probability: FAILED **");
        $finish;
    end

endmodule
